// File: rtl/csc_pkg.sv
`timescale 1ns / 1ps
package csc_pkg;

  localparam int unsigned ATAN_ENTRIES = 31;

  localparam logic signed [32:0] TWO_PI_Q28      = 33'sd1686629713;
  localparam logic signed [32:0] PI_LIMIT_Q28    = 33'sd843314856;
  localparam logic        [31:0] RAD_TO_Q31_Q30  = 32'd2734261102;
  localparam logic signed [33:0] CORDIC_GAIN_Q31 = 34'sd1304065748;
  localparam logic signed [32:0] QUARTER_TURN    = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN       = 33'sd2147483648;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
  } csc_rot_t;

  function automatic logic [29:0] atan_unit(input int unsigned idx);
    logic [29:0] r;
    case (idx)
      0:       r = 30'd536870912;
      1:       r = 30'd316933406;
      2:       r = 30'd167458907;
      3:       r = 30'd85004756;
      4:       r = 30'd42667331;
      5:       r = 30'd21354465;
      6:       r = 30'd10679838;
      7:       r = 30'd5340245;
      8:       r = 30'd2670163;
      9:       r = 30'd1335087;
      10:      r = 30'd667544;
      11:      r = 30'd333772;
      12:      r = 30'd166886;
      13:      r = 30'd83443;
      14:      r = 30'd41722;
      15:      r = 30'd20861;
      16:      r = 30'd10430;
      17:      r = 30'd5215;
      18:      r = 30'd2608;
      19:      r = 30'd1304;
      20:      r = 30'd652;
      21:      r = 30'd326;
      22:      r = 30'd163;
      23:      r = 30'd81;
      24:      r = 30'd41;
      25:      r = 30'd20;
      26:      r = 30'd10;
      27:      r = 30'd5;
      28:      r = 30'd3;
      29:      r = 30'd1;
      30:      r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat_q31(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/csc_in_if.sv
`timescale 1ns / 1ps
interface csc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_radians;

  modport source (output valid, output angle_radians, input ready);
  modport sink   (input valid, input angle_radians, output ready);
endinterface

// File: rtl/csc_out_if.sv
`timescale 1ns / 1ps
interface csc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cosine_value;
  logic signed [31:0] sine_value;

  modport source (output valid, output cosine_value, output sine_value, input ready);
  modport sink   (input valid, input cosine_value, input sine_value, output ready);
endinterface

// File: rtl/csc_angle.sv
`timescale 1ns / 1ps
module csc_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  csc_in_if.sink              angle_i,
  output logic                valid_o,
  output csc_pkg::csc_rot_t   rot_o,
  input  logic                ready_i
);
  import csc_pkg::*;

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_in;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] en;

  logic signed [32:0] rem_d, rem_q;
  logic signed [32:0] wrap;
  logic               neg_d, neg_q, neg2_q;
  logic        [29:0] abs_d, abs_q;
  logic        [61:0] prod_d, prod_q;
  logic signed [34:0] q_ext;
  logic signed [31:0] q_d, q_q;
  logic signed [32:0] z_ext;
  csc_rot_t           rot_d, rot_q;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_in = {vld_q[NSTG-2:0], angle_i.valid};
    en     = vld_in & rdy;
  end

  // remainder by two pi: quotient is at most one in magnitude
  always_comb begin
    logic signed [32:0] a33;
    a33 = {angle_i.angle_radians[31], angle_i.angle_radians};
    if (a33 >= TWO_PI_Q28) begin
      rem_d = a33 - TWO_PI_Q28;
    end else if (a33 <= -TWO_PI_Q28) begin
      rem_d = a33 + TWO_PI_Q28;
    end else begin
      rem_d = a33;
    end
  end

  always_comb begin
    logic signed [32:0] mag;
    if (rem_q > PI_LIMIT_Q28) begin
      wrap = rem_q - TWO_PI_Q28;
    end else if (rem_q < -PI_LIMIT_Q28) begin
      wrap = rem_q + TWO_PI_Q28;
    end else begin
      wrap = rem_q;
    end
    neg_d = wrap[32];
    mag   = neg_d ? -wrap : wrap;
    abs_d = mag[29:0];
  end

  assign prod_d = 62'(abs_q) * 62'(RAD_TO_Q31_Q30);

  always_comb begin
    logic signed [34:0] m35;
    m35   = $signed({3'b000, prod_q[61:30]});
    q_ext = neg2_q ? -m35 : m35;
    q_d   = sat_q31(q_ext);
  end

  // fold into plus or minus a quarter turn
  always_comb begin
    z_ext      = {q_q[31], q_q};
    rot_d.x    = CORDIC_GAIN_Q31;
    rot_d.y    = '0;
    rot_d.flip = 1'b0;
    rot_d.z    = z_ext;
    if (z_ext > QUARTER_TURN) begin
      rot_d.z    = z_ext - HALF_TURN;
      rot_d.flip = 1'b1;
    end else if (z_ext < -QUARTER_TURN) begin
      rot_d.z    = z_ext + HALF_TURN;
      rot_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q <= rem_d;
    end
    if (en[1]) begin
      abs_q <= abs_d;
      neg_q <= neg_d;
    end
    if (en[2]) begin
      prod_q <= prod_d;
      neg2_q <= neg_q;
    end
    if (en[3]) begin
      q_q <= q_d;
    end
    if (en[4]) begin
      rot_q <= rot_d;
    end
  end

  assign angle_i.ready = rdy[0];
  assign valid_o       = vld_q[NSTG-1];
  assign rot_o         = rot_q;

  a_abs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> ($signed({3'b000, abs_q}) <= PI_LIMIT_Q28))
    else $error("wrapped angle beyond pi");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-1] |-> (rot_q.z <= QUARTER_TURN && rot_q.z >= -QUARTER_TURN))
    else $error("folded angle beyond a quarter turn");

  a_fold_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-1] |-> (rot_q.x == CORDIC_GAIN_Q31 && rot_q.y == '0))
    else $error("rotation seed corrupted");

endmodule

// File: rtl/csc_cell.sv
`timescale 1ns / 1ps
module csc_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csc_pkg::csc_rot_t rot_i,
  output logic              ready_o,
  output logic              valid_o,
  output csc_pkg::csc_rot_t rot_o,
  input  logic              ready_i
);
  import csc_pkg::*;

  localparam logic signed [32:0] ATAN_STEP = $signed({3'b000, atan_unit(SHIFT)});

  logic               valid_q;
  csc_rot_t           rot_d, rot_q;
  logic signed [33:0] dx, dy;

  assign dx = rot_i.y >>> SHIFT;
  assign dy = rot_i.x >>> SHIFT;

  always_comb begin
    rot_d.flip = rot_i.flip;
    if (!rot_i.z[32]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - ATAN_STEP;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + ATAN_STEP;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

// File: rtl/csc_out.sv
`timescale 1ns / 1ps
module csc_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csc_pkg::csc_rot_t rot_i,
  output logic              ready_o,
  csc_out_if.source         result_o
);
  import csc_pkg::*;

  logic               valid_q;
  logic signed [34:0] x_ext, y_ext;
  logic signed [31:0] cos_d, cos_q, sin_d, sin_q;

  always_comb begin
    x_ext = $signed({rot_i.x[33], rot_i.x});
    y_ext = $signed({rot_i.y[33], rot_i.y});
    if (rot_i.flip) begin
      x_ext = -x_ext;
      y_ext = -y_ext;
    end
    cos_d = sat_q31(x_ext);
    sin_d = sat_q31(y_ext);
  end

  assign ready_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.cosine_value = cos_q;
  assign result_o.sine_value   = sin_q;

endmodule

// File: rtl/cordic_sine_cosine_core.sv
`timescale 1ns / 1ps
// CORDIC sine and cosine of an angle in radians.
// Input channel angle_i: one beat carries angle_radians, signed Q4.28.
// Output channel result_o: one beat per angle with cosine_value and
// sine_value, signed q1.31, in input order.
// The angle is wrapped into plus or minus pi, scaled to q1.31 half turns and
// folded to a quarter turn in five front stages, then rotated by a chain of
// min(CORDIC_STAGES, 31) CORDIC cells, one shift-add step each, and saturated
// in an output register.
// Throughput: one angle per cycle while the receiver does not stall, set by one cell per rotation step.
// Reset clears only the valid flags of every stage; the pipeline comes up
// empty and ready.
// When the receiver stalls, the held stages keep their data, bubbles behind
// them close up, and angle_i.ready falls only once every stage is full.
module cordic_sine_cosine_core #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csc_in_if.sink    angle_i,
  csc_out_if.source result_o
);
  import csc_pkg::*;

  localparam int unsigned NUM_CELLS =
      (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic     [NUM_CELLS:0] vld;
  logic     [NUM_CELLS:0] rdy;
  csc_rot_t               rot [NUM_CELLS+1];

  csc_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .angle_i (angle_i),
    .valid_o (vld[0]),
    .rot_o   (rot[0]),
    .ready_i (rdy[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    csc_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .rot_i   (rot[g]),
      .ready_o (rdy[g]),
      .valid_o (vld[g+1]),
      .rot_o   (rot[g+1]),
      .ready_i (rdy[g+1])
    );
  end

  csc_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld[NUM_CELLS]),
    .rot_i    (rot[NUM_CELLS]),
    .ready_o  (rdy[NUM_CELLS]),
    .result_o (result_o)
  );

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!result_o.valid && vld == '0) |-> angle_i.ready)
    else $error("empty pipeline refuses an angle");

  a_out_empty_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> rdy[NUM_CELLS])
    else $error("output stage empty but not taking a beat");

endmodule
